// ===== src/drt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the delivery retry table.
// No dependencies; imported by the interfaces, the top level and the checker.
package drt_pkg;

    localparam int OP_W    = 2;
    localparam int KEY_W   = 32;
    localparam int TRIES_W = 4;
    localparam int OCC_W   = 4;

    localparam logic [OP_W-1:0] OP_BEGIN   = 2'd0;
    localparam logic [OP_W-1:0] OP_SUCCEED = 2'd1;
    localparam logic [OP_W-1:0] OP_FAIL    = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

    localparam logic [TRIES_W-1:0] MAX_TRIES_RESET = 4'd3;

    // Per-entry retry state held in the entry memory.
    typedef struct packed {
        logic [TRIES_W-1:0] tries;
        logic               flight;
    } t_ent;

endpackage

// ===== src/drt_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces for the delivery retry table.
// Depends on drt_pkg.
interface drt_req_if
    import drt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface drt_rsp_if
    import drt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               granted;
    logic               gave_up;
    logic               outstanding;
    logic [TRIES_W-1:0] tries;
    logic [OCC_W-1:0]   occupancy;
    logic               table_full;

    modport source (output valid, output granted, output gave_up, output outstanding,
                    output tries, output occupancy, output table_full, input ready);
    modport sink   (input valid, input granted, input gave_up, input outstanding,
                    input tries, input occupancy, input table_full, output ready);
endinterface

// ===== src/drt_cam.sv =====
`timescale 1ns / 1ps
// Key store of the delivery retry table: valid bits, keys, parallel match.
// Standalone; used by delivery_retry_table.
module drt_cam #(
    parameter int ENTRIES  = 8,
    parameter int KEY_BITS = 32,
    parameter int SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_set,
    input  logic                i_clr,
    input  logic [SLOT_W-1:0]   i_slot,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [KEY_BITS-1:0] i_look_key,
    output logic                o_hit,
    output logic [SLOT_W-1:0]   o_hit_slot,
    output logic                o_free_ok,
    output logic [SLOT_W-1:0]   o_free_slot
);

    logic [ENTRIES-1:0]  r_valid;
    logic [KEY_BITS-1:0] r_keys [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_set) begin
            r_valid[i_slot] <= 1'b1;
        end else if (i_clr) begin
            r_valid[i_slot] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_set) begin
            r_keys[i_slot] <= i_key;
        end
    end

    // Lowest-indexed match and lowest-indexed free entry.
    always_comb begin
        o_hit       = 1'b0;
        o_hit_slot  = '0;
        o_free_ok   = 1'b0;
        o_free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_keys[i] == i_look_key)) begin
                o_hit      = 1'b1;
                o_hit_slot = SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                o_free_ok   = 1'b1;
                o_free_slot = SLOT_W'(i);
            end
        end
    end

endmodule

// ===== src/delivery_retry_table.sv =====
`timescale 1ns / 1ps
// Delivery retry table: top level. A request is taken only when idle or as the
// current one retires; it is looked up in the key store the next cycle (which
// also issues the entry memory read), then executed, and the response register
// is loaded as it retires, which waits on a stalled response. The entry memory
// read-modify-write sets that pace. Synchronous active-low reset empties the table
// and sets max_tries to 3; no clearing pass. Depends on drt_pkg, drt_if, drt_cam.
module delivery_retry_table
    import drt_pkg::*;
#(
    parameter int ENTRIES  = 8,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drt_req_if.sink     i_req,
    drt_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int COUNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    // Configuration register: max_tries at byte address 0.
    logic [TRIES_W-1:0] r_max_tries;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {28'd0, r_max_tries} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tries <= MAX_TRIES_RESET;
        end else if (w_cfg_wr) begin
            r_max_tries <= pwdata[TRIES_W-1:0];
        end
    end

    // Sequencer and request capture.
    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [OP_W-1:0]     r_op;
    logic [KEY_BITS-1:0] r_key;
    logic                w_accept;
    logic                w_out_free;
    logic                w_exec_done;

    assign w_out_free  = !o_rsp.valid || o_rsp.ready;
    assign w_exec_done = (r_state == S_EXEC) && w_out_free;
    // Take a new request when idle or as the current one retires.
    assign i_req.ready = (r_state == S_IDLE) || w_exec_done;
    assign w_accept    = i_req.valid && i_req.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_LOOK;
            S_LOOK: n_state = S_EXEC;
            S_EXEC: begin
                if (w_exec_done) begin
                    n_state = w_accept ? S_LOOK : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_req.op;
            r_key <= KEY_BITS'(i_req.key);
        end
    end

    // Key store.
    logic              w_cam_set;
    logic              w_cam_clr;
    logic [SLOT_W-1:0] w_cam_slot;
    logic              w_hit;
    logic [SLOT_W-1:0] w_hit_slot;
    logic              w_free_ok;
    logic [SLOT_W-1:0] w_free_slot;

    drt_cam #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .SLOT_W   (SLOT_W)
    ) u_cam (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_set       (w_cam_set),
        .i_clr       (w_cam_clr),
        .i_slot      (w_cam_slot),
        .i_key       (r_key),
        .i_look_key  (r_key),
        .o_hit       (w_hit),
        .o_hit_slot  (w_hit_slot),
        .o_free_ok   (w_free_ok),
        .o_free_slot (w_free_slot)
    );

    // Hold the lookup result for the execute cycle.
    logic              r_hit;
    logic [SLOT_W-1:0] r_hit_slot;
    logic              r_free_ok;
    logic [SLOT_W-1:0] r_free_slot;

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_hit       <= w_hit;
            r_hit_slot  <= w_hit_slot;
            r_free_ok   <= w_free_ok;
            r_free_slot <= w_free_slot;
        end
    end

    // Entry memory: tries and in-flight flag, registered read. An entry is
    // written on allocation before a read of it is used, so it needs no reset.
    // The write in one execute cycle lands before the next lookup reads.
    t_ent              r_mem [ENTRIES];
    t_ent              r_rd;
    logic              w_mem_we;
    t_ent              w_mem_wdata;

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_rd <= r_mem[w_hit_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_done && w_mem_we) begin
            r_mem[w_cam_slot] <= w_mem_wdata;
        end
    end

    // Execute: compute the response and the updates.
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [TRIES_W-1:0] w_next_tries;
    logic               n_granted;
    logic               n_gave_up;
    logic               n_outstanding;
    logic [TRIES_W-1:0] n_tries;
    logic               n_full;
    logic               w_set;
    logic               w_clr;

    assign w_next_tries = r_rd.tries + 1'b1;

    always_comb begin
        n_granted     = 1'b0;
        n_gave_up     = 1'b0;
        n_outstanding = 1'b0;
        n_tries       = '0;
        n_full        = 1'b0;
        n_count       = r_count;
        w_set         = 1'b0;
        w_clr         = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_wdata   = r_rd;
        w_cam_slot    = r_hit_slot;
        case (r_op)
            OP_BEGIN: begin
                if (r_hit) begin
                    n_outstanding = 1'b1;
                    n_tries       = r_rd.tries;
                    if (!r_rd.flight) begin
                        n_granted          = 1'b1;
                        w_mem_we           = 1'b1;
                        w_mem_wdata.flight = 1'b1;
                    end
                end else if (r_free_ok) begin
                    // Allocate the lowest free entry, in flight with no tries.
                    w_cam_slot         = r_free_slot;
                    w_set              = 1'b1;
                    w_mem_we           = 1'b1;
                    w_mem_wdata.tries  = '0;
                    w_mem_wdata.flight = 1'b1;
                    n_granted          = 1'b1;
                    n_outstanding      = 1'b1;
                    n_count            = r_count + 1'b1;
                end else begin
                    n_full = 1'b1;
                end
            end
            OP_SUCCEED: begin
                if (r_hit) begin
                    w_clr   = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            OP_FAIL: begin
                if (r_hit) begin
                    if (w_next_tries >= r_max_tries) begin
                        // Limit reached: drop the entry.
                        w_clr     = 1'b1;
                        n_gave_up = 1'b1;
                        n_count   = r_count - 1'b1;
                    end else begin
                        w_mem_we           = 1'b1;
                        w_mem_wdata.tries  = w_next_tries;
                        w_mem_wdata.flight = 1'b0;
                        n_tries            = w_next_tries;
                    end
                end
            end
            OP_QUERY: begin
                if (r_hit) begin
                    n_outstanding = r_rd.flight;
                    n_tries       = r_rd.tries;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign w_cam_set = w_exec_done && w_set;
    assign w_cam_clr = w_exec_done && w_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_exec_done) begin
            r_count <= n_count;
        end
    end

    // Response register: parts the response side from the request side.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_done) begin
            o_rsp.granted     <= n_granted;
            o_rsp.gave_up     <= n_gave_up;
            o_rsp.outstanding <= n_outstanding;
            o_rsp.tries       <= n_tries;
            o_rsp.occupancy   <= OCC_W'(n_count);
            o_rsp.table_full  <= n_full;
        end
    end

    assign o_rsp.valid = r_out_valid;

endmodule

// ===== src/drt_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for delivery_retry_table, attached by bind.
// Depends on drt_pkg and the top level's ports.
module drt_props
    import drt_pkg::*;
#(
    parameter int ENTRIES = 8
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               granted,
    input logic               gave_up,
    input logic               outstanding,
    input logic [TRIES_W-1:0] tries,
    input logic [OCC_W-1:0]   occupancy,
    input logic               table_full
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(ENTRIES);

    // Stalled response holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(occupancy) && $stable(tries))
        else $error("response changed while stalled");

    // Paced: no request accepted right after another.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted in back-to-back cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(granted && table_full))
        else $error("grant and table full together");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gave_up |-> !outstanding && (tries == '0) && !granted)
        else $error("give-up left entry state visible");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> occupancy == FULL_OCC)
        else $error("table full reported below capacity");

endmodule

bind delivery_retry_table drt_props #(
    .ENTRIES (ENTRIES)
) u_drt_props (
    .clk         (i_clk),
    .rst_n       (i_rst_n),
    .in_valid    (i_req.valid),
    .in_ready    (i_req.ready),
    .out_valid   (o_rsp.valid),
    .out_ready   (o_rsp.ready),
    .granted     (o_rsp.granted),
    .gave_up     (o_rsp.gave_up),
    .outstanding (o_rsp.outstanding),
    .tries       (o_rsp.tries),
    .occupancy   (o_rsp.occupancy),
    .table_full  (o_rsp.table_full)
);
